// ===== rtl/pgen_pkg.sv =====
package pgen_pkg;

  // sizes
  localparam int MAX_LENGTH = 1024;
  localparam int ADDR_W     = $clog2(MAX_LENGTH);  // store address / swap position
  localparam int LEN_W      = ADDR_W + 1;          // values 1..MAX_LENGTH
  localparam int HALF_W     = 15;                  // one random half
  localparam int DRAW_W     = 2 * HALF_W;          // full draw
  localparam int CNT_W      = $clog2(DRAW_W);      // remainder step counter
  localparam int FUNC_W     = 2;
  localparam int MODE_W     = 2;
  localparam int STAT_W     = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = LEN_W;

  // stream packing
  localparam int IN_DATA_W  = 2 * HALF_W + ADDR_W;                    // 40, whole bytes
  localparam int OUT_RAW_W  = LEN_W + 1;
  localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;
  localparam int OUT_PAD_W  = OUT_DATA_W - OUT_RAW_W;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORDER_MODE = 1'd1;

  // order modes
  localparam logic [MODE_W-1:0] MODE_ASC    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DESC   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RANDOM = 2'd2;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_START   = 2'd0,
    FUNC_SHUFFLE = 2'd1,
    FUNC_READ    = 2'd2
  } func_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_RANGE   = 2'd1,
    ST_IGNORED = 2'd2
  } status_t;

  // datapath action of one micro step
  typedef enum logic [3:0] {
    OP_NOP,
    OP_TAKE,       // ready high, latch word
    OP_FILL_INIT,
    OP_FILL_WR,
    OP_FILL_END,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_RD_POS,
    OP_RD_J,
    OP_WR_POS,
    OP_WR_J,
    OP_RD_IDX,
    OP_RES_VAL,
    OP_RES_RANGE,
    OP_RES_IGN,
    OP_EMIT
  } op_t;

  // jump condition
  typedef enum logic [3:0] {
    CND_NONE,
    CND_ALWAYS,
    CND_ACCEPT,
    CND_IS_START,
    CND_IS_SHUF,
    CND_IS_READ,
    CND_NOT_ARMED,
    CND_NOT_FILLED,
    CND_OUT_RANGE,
    CND_FILL_LAST,
    CND_DIV_LAST,
    CND_OUT_FREE
  } cond_t;

  localparam int STEP_W = 5;

  localparam logic [STEP_W-1:0] STEP_WAIT      = 5'd0;
  localparam logic [STEP_W-1:0] STEP_DSP_START = 5'd1;
  localparam logic [STEP_W-1:0] STEP_DSP_SHUF  = 5'd2;
  localparam logic [STEP_W-1:0] STEP_DSP_READ  = 5'd3;
  localparam logic [STEP_W-1:0] STEP_IGNORE    = 5'd4;
  localparam logic [STEP_W-1:0] STEP_FILL_INIT = 5'd5;
  localparam logic [STEP_W-1:0] STEP_FILL_LOOP = 5'd6;
  localparam logic [STEP_W-1:0] STEP_FILL_END  = 5'd7;
  localparam logic [STEP_W-1:0] STEP_SH_CHK    = 5'd8;
  localparam logic [STEP_W-1:0] STEP_SH_DIV    = 5'd9;
  localparam logic [STEP_W-1:0] STEP_SH_RD_POS = 5'd10;
  localparam logic [STEP_W-1:0] STEP_SH_RD_J   = 5'd11;
  localparam logic [STEP_W-1:0] STEP_SH_WR_POS = 5'd12;
  localparam logic [STEP_W-1:0] STEP_SH_WR_J   = 5'd13;
  localparam logic [STEP_W-1:0] STEP_RD_CHK    = 5'd14;
  localparam logic [STEP_W-1:0] STEP_RD_ISSUE  = 5'd15;
  localparam logic [STEP_W-1:0] STEP_RD_DONE   = 5'd16;
  localparam logic [STEP_W-1:0] STEP_RANGE     = 5'd17;
  localparam logic [STEP_W-1:0] STEP_EMIT      = 5'd18;

  // hold: stay on this step while the condition is false
  typedef struct packed {
    op_t               op;
    cond_t             cond;
    logic [STEP_W-1:0] target;
    logic              hold;
  } uword_t;

  function automatic uword_t ucode(input logic [STEP_W-1:0] step);
    uword_t w;
    w = '{op: OP_NOP, cond: CND_ALWAYS, target: STEP_WAIT, hold: 1'b0};
    case (step)
      STEP_WAIT:      w = '{OP_TAKE,      CND_ACCEPT,     STEP_DSP_START, 1'b1};
      STEP_DSP_START: w = '{OP_NOP,       CND_IS_START,   STEP_FILL_INIT, 1'b0};
      STEP_DSP_SHUF:  w = '{OP_NOP,       CND_IS_SHUF,    STEP_SH_CHK,    1'b0};
      STEP_DSP_READ:  w = '{OP_NOP,       CND_IS_READ,    STEP_RD_CHK,    1'b0};
      STEP_IGNORE:    w = '{OP_RES_IGN,   CND_ALWAYS,     STEP_EMIT,      1'b0};
      STEP_FILL_INIT: w = '{OP_FILL_INIT, CND_NONE,       STEP_WAIT,      1'b0};
      STEP_FILL_LOOP: w = '{OP_FILL_WR,   CND_FILL_LAST,  STEP_FILL_END,  1'b1};
      STEP_FILL_END:  w = '{OP_FILL_END,  CND_ALWAYS,     STEP_EMIT,      1'b0};
      STEP_SH_CHK:    w = '{OP_DIV_INIT,  CND_NOT_ARMED,  STEP_IGNORE,    1'b0};
      STEP_SH_DIV:    w = '{OP_DIV_STEP,  CND_DIV_LAST,   STEP_SH_RD_POS, 1'b1};
      STEP_SH_RD_POS: w = '{OP_RD_POS,    CND_NONE,       STEP_WAIT,      1'b0};
      STEP_SH_RD_J:   w = '{OP_RD_J,      CND_NONE,       STEP_WAIT,      1'b0};
      STEP_SH_WR_POS: w = '{OP_WR_POS,    CND_NONE,       STEP_WAIT,      1'b0};
      STEP_SH_WR_J:   w = '{OP_WR_J,      CND_ALWAYS,     STEP_EMIT,      1'b0};
      STEP_RD_CHK:    w = '{OP_NOP,       CND_NOT_FILLED, STEP_IGNORE,    1'b0};
      STEP_RD_ISSUE:  w = '{OP_RD_IDX,    CND_OUT_RANGE,  STEP_RANGE,     1'b0};
      STEP_RD_DONE:   w = '{OP_RES_VAL,   CND_ALWAYS,     STEP_EMIT,      1'b0};
      STEP_RANGE:     w = '{OP_RES_RANGE, CND_ALWAYS,     STEP_EMIT,      1'b0};
      STEP_EMIT:      w = '{OP_EMIT,      CND_OUT_FREE,   STEP_WAIT,      1'b1};
      default:        w = '{OP_NOP,       CND_ALWAYS,     STEP_WAIT,      1'b0};
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/permutation_generator.sv =====
// Channel  Dir  Fields (lowest bit first)                          Handshake
// s_*      in   tdata: rand_high[14:0] rand_low[29:15] index[39:30]  s_tvalid/s_tready
//                tuser: func[1:0]
// m_*      out  tdata: value[10:0] shuffle_done[11] zero[15:12]    m_tvalid/m_tready
//                tuser: status[1:0]
// cfg_*    in   cfg_index selects length / order_mode, cfg_data    cfg_we
//
// One word at a time, run by a microcode sequencer over a 1024 x 11 store.
// Start: one store write per cycle in the fill loop.
// Shuffle: a bit-serial remainder loop over the 30 draw bits, then a swap.
// Read: the value comes from the registered store read.
// Synchronous reset clears the sequencer and control state; the store holds
// garbage until the first start, and reads before that are refused.
// A result waits in the output register; the sequencer holds in its last
// step until that register is free, and only then takes the next word.
module permutation_generator (
  input  logic                             clk,
  input  logic                             rst,
  // input stream
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [pgen_pkg::IN_DATA_W-1:0]   s_tdata,   // rand_high, rand_low, index
  input  logic [pgen_pkg::FUNC_W-1:0]      s_tuser,   // func
  // result stream
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [pgen_pkg::OUT_DATA_W-1:0]  m_tdata,   // value, shuffle_done, zero pad
  output logic [pgen_pkg::STAT_W-1:0]      m_tuser,   // status
  // configuration
  input  logic                             cfg_we,
  input  logic [pgen_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pgen_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import pgen_pkg::*;

  // sequencer
  logic [STEP_W-1:0] upc;
  logic [STEP_W-1:0] upc_next;
  uword_t            uw;
  logic              cond_true;

  // config registers
  logic [LEN_W-1:0]  reg_length;
  logic [MODE_W-1:0] reg_order_mode;

  // block state
  logic              filled;
  logic [ADDR_W-1:0] pos;      // swap position
  logic [LEN_W-1:0]  n_act;    // N latched at start
  logic [LEN_W-1:0]  last_pos; // N - 1

  // latched word
  func_t             func_r;
  logic [DRAW_W-1:0] draw;
  logic [ADDR_W-1:0] idx_r;

  // fill and remainder datapath
  logic [LEN_W-1:0]  k;
  logic [LEN_W-1:0]  fill_len;
  logic [ADDR_W-1:0] rem;
  logic [CNT_W-1:0]  div_cnt;
  logic [LEN_W-1:0]  div_d;
  logic [LEN_W-1:0]  rem_shift;
  logic [LEN_W-1:0]  rem_sub;
  logic [LEN_W-1:0]  tmp;

  // result being built and output register
  logic [LEN_W-1:0]  res_value;
  status_t           res_status;
  logic [LEN_W-1:0]  o_value;
  logic              o_done;
  status_t           o_status;
  logic              out_free;

  // store
  logic [LEN_W-1:0]  perm_store [MAX_LENGTH];
  logic              mem_we;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_waddr;
  logic [ADDR_W-1:0] mem_raddr;
  logic [LEN_W-1:0]  mem_wdata;
  logic [LEN_W-1:0]  rdata;

  assign uw       = ucode(upc);
  assign s_tready = (uw.op == OP_TAKE);
  assign out_free = !m_tvalid || m_tready;
  assign last_pos = n_act - LEN_W'(1);

  // length 0 runs as 1, anything past the store as the store size
  always_comb begin
    if (reg_length == '0) begin
      fill_len = LEN_W'(1);
    end else if (reg_length > LEN_W'(MAX_LENGTH)) begin
      fill_len = LEN_W'(MAX_LENGTH);
    end else begin
      fill_len = reg_length;
    end
  end

  // restoring remainder, one draw bit per step; rem stays below div_d
  assign div_d     = {1'b0, pos} + LEN_W'(1);
  assign rem_shift = {rem, draw[DRAW_W-1]};
  assign rem_sub   = rem_shift - div_d;

  // jump conditions
  always_comb begin
    case (uw.cond)
      CND_NONE:       cond_true = 1'b0;
      CND_ALWAYS:     cond_true = 1'b1;
      CND_ACCEPT:     cond_true = s_tvalid;
      CND_IS_START:   cond_true = (func_r == FUNC_START);
      CND_IS_SHUF:    cond_true = (func_r == FUNC_SHUFFLE);
      CND_IS_READ:    cond_true = (func_r == FUNC_READ);
      CND_NOT_ARMED:  cond_true = !filled || (pos == '0);
      CND_NOT_FILLED: cond_true = !filled;
      CND_OUT_RANGE:  cond_true = ({1'b0, idx_r} >= n_act);
      CND_FILL_LAST:  cond_true = (k == n_act - LEN_W'(1));
      CND_DIV_LAST:   cond_true = (div_cnt == CNT_W'(DRAW_W - 1));
      CND_OUT_FREE:   cond_true = out_free;
      default:        cond_true = 1'b1;
    endcase
  end

  always_comb begin
    if (cond_true) begin
      upc_next = uw.target;
    end else if (uw.hold) begin
      upc_next = upc;
    end else begin
      upc_next = upc + STEP_W'(1);
    end
  end

  // store port control
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = k[ADDR_W-1:0];
    mem_raddr = pos;
    mem_wdata = rdata;
    case (uw.op)
      OP_FILL_WR: begin
        mem_we    = 1'b1;
        mem_waddr = k[ADDR_W-1:0];
        mem_wdata = (reg_order_mode == MODE_DESC) ? (n_act - k) : (k + LEN_W'(1));
      end
      OP_RD_POS: begin
        mem_re    = 1'b1;
        mem_raddr = pos;
      end
      OP_RD_J: begin
        mem_re    = 1'b1;
        mem_raddr = rem;
      end
      OP_WR_POS: begin
        mem_we    = 1'b1;
        mem_waddr = pos;
        mem_wdata = rdata;   // entry j
      end
      OP_WR_J: begin
        mem_we    = 1'b1;
        mem_waddr = rem;
        mem_wdata = tmp;     // old entry at pos
      end
      OP_RD_IDX: begin
        mem_re    = 1'b1;
        mem_raddr = idx_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      perm_store[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata <= perm_store[mem_raddr];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      upc            <= STEP_WAIT;
      filled         <= 1'b0;
      pos            <= '0;
      n_act          <= LEN_W'(1);
      reg_length     <= LEN_W'(MAX_LENGTH);
      reg_order_mode <= MODE_ASC;
      m_tvalid       <= 1'b0;
    end else begin
      upc <= upc_next;
      if (cfg_we) begin
        case (cfg_index)
          REG_LENGTH:     reg_length     <= cfg_data;
          REG_ORDER_MODE: reg_order_mode <= cfg_data[MODE_W-1:0];
          default: begin
          end
        endcase
      end
      case (uw.op)
        OP_FILL_INIT: n_act <= fill_len;
        OP_FILL_END: begin
          filled <= 1'b1;
          pos    <= (reg_order_mode == MODE_RANDOM) ? last_pos[ADDR_W-1:0]
                                                    : '0;
        end
        OP_WR_J: pos <= pos - ADDR_W'(1);
        default: begin
        end
      endcase
      if (uw.op == OP_EMIT && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // payload and datapath registers
  always_ff @(posedge clk) begin
    case (uw.op)
      OP_TAKE: begin
        if (s_tvalid) begin
          func_r <= func_t'(s_tuser);
          draw   <= {s_tdata[HALF_W-1:0], s_tdata[2*HALF_W-1:HALF_W]};
          idx_r  <= s_tdata[IN_DATA_W-1:2*HALF_W];
        end
      end
      OP_FILL_INIT: k <= '0;
      OP_FILL_WR:   k <= k + LEN_W'(1);
      OP_FILL_END: begin
        res_value  <= '0;
        res_status <= ST_OK;
      end
      OP_DIV_INIT: begin
        rem     <= '0;
        div_cnt <= '0;
      end
      OP_DIV_STEP: begin
        rem     <= (rem_shift >= div_d) ? rem_sub[ADDR_W-1:0] : rem_shift[ADDR_W-1:0];
        draw    <= {draw[DRAW_W-2:0], 1'b0};
        div_cnt <= div_cnt + CNT_W'(1);
      end
      OP_RD_J: tmp <= rdata;
      OP_WR_J: begin
        res_value  <= '0;
        res_status <= ST_OK;
      end
      OP_RES_VAL: begin
        res_value  <= rdata;
        res_status <= ST_OK;
      end
      OP_RES_RANGE: begin
        res_value  <= '0;
        res_status <= ST_RANGE;
      end
      OP_RES_IGN: begin
        res_value  <= '0;
        res_status <= ST_IGNORED;
      end
      OP_EMIT: begin
        if (out_free) begin
          o_value  <= res_value;
          o_done   <= (pos == '0);
          o_status <= res_status;
        end
      end
      default: begin
      end
    endcase
  end

  assign m_tdata = {{OUT_PAD_W{1'b0}}, o_done, o_value};
  assign m_tuser = o_status;

  // a taken word always goes to dispatch
  a_take_dispatch: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> upc == STEP_DSP_START)
    else $error("accepted word not dispatched");

  // remainder stays below the divisor throughout the loop
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    upc == STEP_SH_DIV |-> ({1'b0, rem} < div_d))
    else $error("remainder not below divisor");

  // the remainder loop never overruns the draw width
  a_div_count: assert property (@(posedge clk) disable iff (rst)
    upc == STEP_SH_DIV |-> div_cnt <= CNT_W'(DRAW_W - 1))
    else $error("remainder loop overran");

  // swaps only happen on an armed store
  a_swap_armed: assert property (@(posedge clk) disable iff (rst)
    upc == STEP_SH_RD_POS |-> filled && pos != '0)
    else $error("swap on unarmed store");

  // once filled, the store stays filled
  a_filled_sticky: assert property (@(posedge clk) disable iff (rst)
    filled |=> filled)
    else $error("filled dropped");

endmodule
